FILE: rtl/mdt_pkg.sv
// Shared types, constants and helpers for the multi-delimiter tokenizer.
// Used by the top level, mdt_cell and mdt_match in rtl/; depends on nothing.
package mdt_pkg;

  localparam int SEP_SLOTS   = 4;
  localparam int SEP_MAX_LEN = 4;
  localparam int POS_BITS    = 16;

  // Separator registers on the config port: four slots of four bytes each.
  localparam int SEP_REGS      = 4;
  localparam int BYTES_PER_SEP = 4;

  localparam int NSLOT  = (SEP_SLOTS < SEP_REGS) ? SEP_SLOTS : SEP_REGS;
  localparam int NLEN   = (SEP_MAX_LEN < BYTES_PER_SEP) ? SEP_MAX_LEN : BYTES_PER_SEP;
  localparam int WIN    = SEP_MAX_LEN;
  localparam int FILL_W = $clog2(WIN + 1);
  localparam int LEN_W  = $clog2(NLEN + 1);
  localparam int SKIP_W = (NLEN > 1) ? $clog2(NLEN) : 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int FIELD_W    = 16;

  typedef logic [7:0]             byte_t;
  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [FILL_W-1:0]      fill_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [NSLOT-1:0]       slot_vec_t;
  typedef logic [NSLOT-1:0][7:0]  sep_col_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_COUNT    = 3'd0,
    REG_SEP_LEN_PACK = 3'd1,
    REG_SEP_BYTES_0  = 3'd2,
    REG_SEP_BYTES_1  = 3'd3,
    REG_SEP_BYTES_2  = 3'd4,
    REG_SEP_BYTES_3  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_in;  // take the incoming byte
    logic shift;    // take the neighbor's byte
    logic cmp_in;   // compare the incoming byte instead of the held one
  } cell_ctrl_t;

  // Separator length of a slot, clipped to the window and register limits.
  function automatic len_t slot_len(logic [7:0] pack, int s);
    logic [2:0] l;
    l = {1'b0, pack[2*s +: 2]} + 3'd1;
    if (int'(l) > NLEN) l = 3'(NLEN);
    return LEN_W'(l);
  endfunction

endpackage

FILE: rtl/multi_delimiter_tokenizer.sv
// Top level of the multi-delimiter tokenizer: config registers, control, window
// cell chain and output register. Depends on mdt_pkg, mdt_cell and mdt_match.
//
// The string arrives one byte per beat; end_of_string rides on the last byte.
// Up to four separators (1..4 bytes) are tried in slot order at each position;
// the first hit closes the current token, which leaves as one beat of
// (token_start, token_len), and the separator bytes are skipped. A row of
// SEP_MAX_LEN cells holds the lookahead window and shifts once per decided
// position, each cell comparing its byte against every separator column.
// Ordinary bytes go at one per cycle: once the window is full the incoming byte
// joins the compare directly, so a byte is accepted every cycle while the
// output can take a beat. The end-of-string byte is followed by a flush that
// decides each window position still held, one per cycle while the output can
// take a beat, and then sends the final token with token_last; input
// is stalled during the flush. A stalled output register also stalls input.
// Separators only partly present at the string end never match. Positions
// saturate at 2^POS_BITS - 1. There is no clearing pass after reset.
module multi_delimiter_tokenizer (
  input  logic        clk,
  input  logic        rst,
  // input byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  // token channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] token_start,
  output logic [15:0] token_len,
  output logic        token_last,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int WIN = mdt_pkg::WIN;

  // config registers
  logic [2:0]  sep_count;
  logic [7:0]  sep_len_pack;
  logic [31:0] sep_bytes [mdt_pkg::SEP_REGS];

  // per-string state
  mdt_pkg::state_t              state, state_next;
  mdt_pkg::fill_t               fill, fill_next;
  mdt_pkg::pos_t                pos, pos_next;
  mdt_pkg::pos_t                tok_start, tok_start_next;
  logic [mdt_pkg::SKIP_W-1:0]   skip, skip_next;

  // control
  logic          can_load;
  logic          accept_ok;
  logic          in_fire;
  logic          run_dec;
  logic          push_only;
  logic          flush_step;
  logic          flush_end;
  logic          decide;
  logic          emit;
  logic          hit;
  mdt_pkg::len_t mlen;
  mdt_pkg::fill_t avail;
  mdt_pkg::pos_t cur_len;

  // cell chain
  mdt_pkg::cell_ctrl_t ctrl   [WIN];
  mdt_pkg::byte_t      held   [WIN];
  mdt_pkg::slot_vec_t  eq     [WIN];
  mdt_pkg::sep_col_t   col    [WIN];

  function automatic mdt_pkg::pos_t sat_add(mdt_pkg::pos_t a, mdt_pkg::len_t b);
    logic [mdt_pkg::POS_BITS:0] sum;
    sum = {1'b0, a} + (mdt_pkg::POS_BITS + 1)'(b);
    return sum[mdt_pkg::POS_BITS] ? '1 : sum[mdt_pkg::POS_BITS-1:0];
  endfunction

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_count    <= '0;
      sep_len_pack <= '0;
      for (int i = 0; i < mdt_pkg::SEP_REGS; i++) sep_bytes[i] <= '0;
    end else if (cfg_we) begin
      case (mdt_pkg::cfg_reg_t'(cfg_index))
        mdt_pkg::REG_SEP_COUNT:    sep_count    <= cfg_data[2:0];
        mdt_pkg::REG_SEP_LEN_PACK: sep_len_pack <= cfg_data[7:0];
        mdt_pkg::REG_SEP_BYTES_0:  sep_bytes[0] <= cfg_data;
        mdt_pkg::REG_SEP_BYTES_1:  sep_bytes[1] <= cfg_data;
        mdt_pkg::REG_SEP_BYTES_2:  sep_bytes[2] <= cfg_data;
        mdt_pkg::REG_SEP_BYTES_3:  sep_bytes[3] <= cfg_data;
        default: ;  // unused index, dropped
      endcase
    end
  end

  // ---------------- state machine ----------------
  assign can_load = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      mdt_pkg::ST_RUN: begin
        if (in_fire && end_of_string) state_next = mdt_pkg::ST_FLUSH;
      end
      mdt_pkg::ST_FLUSH: begin
        if (flush_end) state_next = mdt_pkg::ST_RUN;
      end
      default: state_next = mdt_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    accept_ok  = 1'b0;
    flush_step = 1'b0;
    flush_end  = 1'b0;
    case (state)
      mdt_pkg::ST_RUN: begin
        accept_ok = can_load;
      end
      mdt_pkg::ST_FLUSH: begin
        flush_step = can_load && (fill != '0);
        flush_end  = can_load && (fill == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdt_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = !accept_ok;
  assign in_fire   = in_valid && accept_ok;
  // window full with this byte: decide the head this cycle
  assign run_dec   = in_fire && !end_of_string && (fill == mdt_pkg::FILL_W'(WIN - 1));
  assign push_only = in_fire && !run_dec;
  assign decide    = run_dec || flush_step;
  assign avail     = run_dec ? mdt_pkg::FILL_W'(WIN) : fill;

  // ---------------- cell chain ----------------
  for (genvar k = 0; k < WIN; k++) begin : g_cell
    for (genvar s = 0; s < mdt_pkg::NSLOT; s++) begin : g_col
      if (k < mdt_pkg::BYTES_PER_SEP) begin : g_byte
        assign col[k][s] = sep_bytes[s][8*k +: 8];
      end else begin : g_none
        assign col[k][s] = 8'h00;
      end
    end

    assign ctrl[k].load_in = (push_only && (fill == mdt_pkg::FILL_W'(k))) ||
                             (run_dec && (k == WIN - 2));
    assign ctrl[k].shift   = decide;
    assign ctrl[k].cmp_in  = (k == WIN - 1) && (state == mdt_pkg::ST_RUN);

    mdt_pkg::byte_t nb;
    if (k == WIN - 1) begin : g_tail
      assign nb = 8'h00;
    end else begin : g_mid
      assign nb = held[k+1];
    end

    mdt_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[k]),
      .in_byte  (in_byte),
      .shift_in (nb),
      .col      (col[k]),
      .held     (held[k]),
      .eq       (eq[k])
    );
  end

  mdt_match u_match (
    .eq           (eq),
    .sep_count    (sep_count),
    .sep_len_pack (sep_len_pack),
    .avail        (avail),
    .hit          (hit),
    .len          (mlen)
  );

  // ---------------- position bookkeeping ----------------
  assign emit    = decide && (skip == '0) && hit;
  assign cur_len = (pos >= tok_start) ? (pos - tok_start) : '0;

  always_comb begin
    fill_next      = fill;
    pos_next       = pos;
    tok_start_next = tok_start;
    skip_next      = skip;
    if (push_only) fill_next = fill + mdt_pkg::FILL_W'(1);
    if (flush_step) fill_next = fill - mdt_pkg::FILL_W'(1);
    if (decide) begin
      pos_next = sat_add(pos, mdt_pkg::LEN_W'(1));
      if (skip != '0) begin
        skip_next = skip - mdt_pkg::SKIP_W'(1);
      end else if (hit) begin
        skip_next      = mdt_pkg::SKIP_W'(mlen - mdt_pkg::LEN_W'(1));
        tok_start_next = sat_add(pos, mlen);
      end
    end
    if (flush_end) begin
      fill_next      = '0;
      pos_next       = '0;
      tok_start_next = '0;
      skip_next      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      pos       <= '0;
      tok_start <= '0;
      skip      <= '0;
    end else begin
      fill      <= fill_next;
      pos       <= pos_next;
      tok_start <= tok_start_next;
      skip      <= skip_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= emit || flush_end;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && (emit || flush_end)) begin
      token_start <= mdt_pkg::FIELD_W'(tok_start);
      token_len   <= mdt_pkg::FIELD_W'(cur_len);
      token_last  <= flush_end;
    end
  end

endmodule

FILE: rtl/mdt_cell.sv
// One window cell: holds one lookahead byte and compares it per separator slot.
// Depends on mdt_pkg.
module mdt_cell (
  input  logic                clk,
  input  mdt_pkg::cell_ctrl_t ctrl,
  input  mdt_pkg::byte_t      in_byte,
  input  mdt_pkg::byte_t      shift_in,
  input  mdt_pkg::sep_col_t   col,
  output mdt_pkg::byte_t      held,
  output mdt_pkg::slot_vec_t  eq
);

  mdt_pkg::byte_t cmp_byte;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      held <= in_byte;
    end else if (ctrl.shift) begin
      held <= shift_in;
    end
  end

  assign cmp_byte = ctrl.cmp_in ? in_byte : held;

  always_comb begin
    for (int s = 0; s < mdt_pkg::NSLOT; s++) begin
      eq[s] = (cmp_byte == col[s]);
    end
  end

endmodule

FILE: rtl/mdt_match.sv
// Priority match over separator slots from the per-cell byte compares.
// Depends on mdt_pkg.
module mdt_match (
  input  mdt_pkg::slot_vec_t eq [mdt_pkg::WIN],
  input  logic [2:0]         sep_count,
  input  logic [7:0]         sep_len_pack,
  input  mdt_pkg::fill_t     avail,
  output logic               hit,
  output mdt_pkg::len_t      len
);

  always_comb begin
    mdt_pkg::len_t l;
    logic          ok;
    hit = 1'b0;
    len = '0;
    // walk from the highest slot down so slot 0 wins
    for (int s = mdt_pkg::NSLOT - 1; s >= 0; s--) begin
      l  = mdt_pkg::slot_len(sep_len_pack, s);
      ok = (sep_count > 3'(s)) && (mdt_pkg::FILL_W'(l) <= avail);
      for (int k = 0; k < mdt_pkg::WIN; k++) begin
        if ((k < int'(l)) && !eq[k][s]) ok = 1'b0;
      end
      if (ok) begin
        hit = 1'b1;
        len = l;
      end
    end
  end

endmodule

FILE: rtl/mdt_checker.sv
// Port-level checks for the multi-delimiter tokenizer, bound to the top level.
// Depends on multi_delimiter_tokenizer's port list only.
module mdt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        end_of_string,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] token_start,
  input logic [15:0] token_len,
  input logic        token_last
);

  // a held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_start) &&
    $stable(token_len) && $stable(token_last))
    else $error("token beat changed while stalled");

  // nothing leaves right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token beat right after reset");

  // a blocked output register blocks the input side
  a_backpress: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output is blocked");

  // the end-of-string byte is always followed by a flush cycle
  a_eos_flush: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && end_of_string |=> in_stall)
    else $error("input taken right after end of string");

endmodule

bind multi_delimiter_tokenizer mdt_checker u_mdt_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .end_of_string (end_of_string),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .token_start   (token_start),
  .token_len     (token_len),
  .token_last    (token_last)
);

FILE: dv/testbench.sv
// Self-checking testbench for multi_delimiter_tokenizer: a cycle-free token predictor
// checks every token beat. Depends on mdt_pkg and the RTL in rtl/.
module testbench;
  import mdt_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_WAIT      = 10;     // per-beat idle / stall draw, 0..MAX_WAIT
  localparam int STALL_LIMIT   = 2000;   // watchdog: cycles with no beat on either side
  localparam int SETTLE_CYCLES = 12;     // margin to cover the flush and the output register
  localparam int HOLD_CYCLES   = 150;    // long receiver hold-off
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BYTES   = 60;

  // Config indexes past the last register; writes there must be dropped.
  localparam logic [2:0] CFG_IDX_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_IDX_SPARE_7 = 3'd7;

  localparam longint unsigned POS_LIMIT = (64'd1 << POS_BITS) - 1;

  typedef struct {
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] token_start;
  logic [15:0] token_len;
  logic        token_last;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'h0;

  always #HALF_PERIOD clk = ~clk;

  multi_delimiter_tokenizer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_start   (token_start),
    .token_len     (token_len),
    .token_last    (token_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Token predictor: shadow config plus its own lookahead window. Called from
  // the sender at the edge a byte beat is accepted, so expectations are queued
  // before the DUT can possibly present the matching token.
  // ---------------------------------------------------------------------------
  logic [2:0]      sep_count_q = 3'd0;
  logic [7:0]      sep_len_q   = 8'h00;
  logic [31:0]     sep_bytes_q [4] = '{default: 32'h0};

  byte_t           window_q [WIN] = '{default: 8'h00};
  int unsigned     window_fill = 0;
  longint unsigned scan_pos    = 0;   // offset of oldest undecided byte
  longint unsigned open_start  = 0;   // start of the token being built
  int unsigned     skip_left   = 0;   // separator bytes still to drop

  token_t          expected_tokens [$];

  int errors         = 0;
  int bytes_sent     = 0;
  int strings_sent   = 0;
  int tokens_checked = 0;
  int config_sets    = 0;
  int quiet_cycles   = 0;

  bit tx_steady   = 1'b0;   // sender offers back to back
  bit rx_steady   = 1'b0;   // receiver adds no random stall
  int rx_hold_left = 0;     // long hold-off request, counted down by the receiver

  // Separator width of a slot: 2-bit field + 1, clipped to window and register size.
  function automatic int unsigned sep_width(int s);
    int unsigned w;
    w = int'((sep_len_q >> (2 * s)) & 8'h03) + 1;
    if (w > SEP_MAX_LEN) w = SEP_MAX_LEN;
    if (w > 4) w = 4;
    return w;
  endfunction

  // Width of the first slot (priority order) that matches at the window head
  // and fits in the bytes at hand; 0 if none.
  function automatic int unsigned first_hit_len(int unsigned avail);
    int unsigned used;
    int unsigned w;
    bit          hit;
    used = sep_count_q;
    if (used > 4) used = 4;
    if (used > SEP_SLOTS) used = SEP_SLOTS;
    for (int s = 0; s < used; s++) begin
      w = sep_width(s);
      if (w > avail) continue;   // partly present separator never matches
      hit = 1'b1;
      for (int k = 0; k < w; k++)
        if (window_q[k] !== sep_bytes_q[s][8*k +: 8]) hit = 1'b0;
      if (hit) return w;
    end
    return 0;
  endfunction

  function automatic longint unsigned pos_add(longint unsigned a, longint unsigned b);
    longint unsigned sum;
    sum = a + b;
    return (sum > POS_LIMIT) ? POS_LIMIT : sum;
  endfunction

  function automatic void queue_token(longint unsigned start, longint unsigned stop, logic last);
    token_t t;
    t.start = start[15:0];
    t.len   = (stop >= start) ? 16'(stop - start) : 16'd0;
    t.last  = last;
    expected_tokens.push_back(t);
  endfunction

  // Settle the oldest window position.
  function automatic void decide_oldest(int unsigned avail);
    int unsigned w;
    if (skip_left > 0) begin
      skip_left--;
    end else begin
      w = first_hit_len(avail);
      if (w > 0) begin
        queue_token(open_start, scan_pos, 1'b0);
        skip_left  = w - 1;
        open_start = pos_add(scan_pos, w);
      end
    end
    if (window_fill > 0) begin
      for (int k = 0; k < WIN - 1; k++) window_q[k] = window_q[k+1];
      window_q[WIN-1] = 8'h00;
      window_fill--;
    end
    scan_pos = pos_add(scan_pos, 1);
  endfunction

  function automatic void predict_byte(byte_t b, logic eos);
    if (window_fill < WIN) begin
      window_q[window_fill] = b;
      window_fill++;
    end
    if (!eos) begin
      if (window_fill >= WIN) decide_oldest(window_fill);
    end else begin
      // end of string: drain the window, then the final (maybe empty) token
      while (window_fill > 0) decide_oldest(window_fill);
      queue_token(open_start, scan_pos, 1'b1);
      window_q    = '{default: 8'h00};
      scan_pos    = 0;
      open_start  = 0;
      skip_left   = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender and config writer
  // ---------------------------------------------------------------------------
  task automatic send_byte(byte_t b, logic eos);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= b;
    end_of_string <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, eos);
    bytes_sent++;
    if (eos) strings_sent++;
  endtask

  task automatic send_string(byte_t s [$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(string t);
    byte_t q [$];
    for (int i = 0; i < t.len(); i++) q.push_back(t[i]);
    send_string(q);
  endtask

  // Drop valid and let every queued token come out, plus the flush margin.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after the last write of a batch.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (cfg_reg_t'(idx))
      REG_SEP_COUNT:    sep_count_q    = val[2:0];
      REG_SEP_LEN_PACK: sep_len_q      = val[7:0];
      REG_SEP_BYTES_0:  sep_bytes_q[0] = val;
      REG_SEP_BYTES_1:  sep_bytes_q[1] = val;
      REG_SEP_BYTES_2:  sep_bytes_q[2] = val;
      REG_SEP_BYTES_3:  sep_bytes_q[3] = val;
      default: ;
    endcase
  endtask

  task automatic load_config(logic [2:0] count, logic [7:0] pack, logic [31:0] b0,
                             logic [31:0] b1, logic [31:0] b2, logic [31:0] b3);
    write_reg(REG_SEP_COUNT, 32'(count));
    write_reg(REG_SEP_LEN_PACK, 32'(pack));
    write_reg(REG_SEP_BYTES_0, b0);
    write_reg(REG_SEP_BYTES_1, b1);
    write_reg(REG_SEP_BYTES_2, b2);
    write_reg(REG_SEP_BYTES_3, b3);
    cfg_we <= 1'b0;
    config_sets++;
  endtask

  // Random string: mostly whole separators, separator fragments and alphabet
  // bytes, some fully random bytes. Trimming to length leaves partial
  // separators at the tail now and then.
  task automatic send_random_string(byte_t alpha [3], int max_len);
    byte_t q [$];
    int    n;
    int    pick;
    int    slot;
    n = $urandom_range(1, max_len);
    while (q.size() < n) begin
      pick = $urandom_range(0, 9);
      slot = $urandom_range(0, 3);
      if (pick < 4)
        for (int k = 0; k < sep_width(slot); k++) q.push_back(sep_bytes_q[slot][8*k +: 8]);
      else if (pick < 6)
        q.push_back(sep_bytes_q[slot][8*$urandom_range(0, 3) +: 8]);
      else if (pick < 8)
        q.push_back(alpha[$urandom_range(0, 2)]);
      else
        q.push_back(8'($urandom_range(0, 255)));
    end
    while (q.size() > n) void'(q.pop_back());
    send_string(q);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall after each token beat, or a long hold on request.
  // ---------------------------------------------------------------------------
  int rx_wait_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      rx_wait_left = 0;
    end else if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left--;
    end else if (out_valid && !out_stall) begin
      rx_wait_left = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      out_stall    <= (rx_wait_left > 0);
    end else if (rx_wait_left > 1) begin
      rx_wait_left--;
    end else begin
      rx_wait_left = 0;
      out_stall    <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Token checker and activity count for the watchdog
  // ---------------------------------------------------------------------------
  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    token_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token, expected none actual start=%0d len=%0d last=%0b",
                 $time, token_start, token_len, token_last);
        errors++;
      end else begin
        want = expected_tokens.pop_front();
        compare_field("token_start", want.start, token_start);
        compare_field("token_len", want.len, token_len);
        compare_field("token_last", 16'(want.last), 16'(token_last));
        tokens_checked++;
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: watchdog, no beat for %0d cycles, %0d tokens outstanding",
             $time, STALL_LIMIT, expected_tokens.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Registers at reset: no separators, so the whole string is one token;
  // a one-byte string is the shortest there is.
  task automatic test_reset_state();
    send_text("ab");
    send_text("Z");
    wait_drain();
  endtask

  // All four slots, widths 1..4: leading separator (empty first token),
  // back-to-back tokens, 0x00/0xFF separator bytes, a separator only partly
  // present at the string end, and a separator as the final byte.
  task automatic test_slot_separators();
    load_config(3'd4, 8'hE4, 32'h0000_002C, 32'h0000_3A3A, 32'h0000_FF00, 32'h6463_6261);
    send_text(",x::y");
    send_text("abc");
    send_string('{8'h00, 8'hFF, 8'h00, 8'h71});
    send_text("ab,");
    wait_drain();
  endtask

  // Count above four is clamped; all widths at the max; register extremes.
  task automatic test_count_clamp();
    load_config(3'd7, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_string('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    wait_drain();
  endtask

  // Writes past the last register index must leave the config alone.
  task automatic test_spare_index();
    write_reg(CFG_IDX_SPARE_6, 32'h0);
    write_reg(CFG_IDX_SPARE_7, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    send_string('{8'h00, 8'h00, 8'h00, 8'h00});
    wait_drain();
  endtask

  // Receiver holds off while the sender streams a token every other byte, so
  // the output register fills and the DUT has to stall input.
  task automatic test_back_pressure();
    byte_t q [$];
    load_config(3'd1, 8'h00, 32'h0000_003B, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 40; i++) q.push_back((i % 2) ? 8'h3B : 8'h61);
    tx_steady    = 1'b1;
    rx_hold_left = HOLD_CYCLES;
    send_string(q);
    tx_steady = 1'b0;
    wait_drain();
  endtask

  // Sender goes quiet mid-string until every token so far has been taken.
  task automatic test_sender_pause();
    byte_t q [$];
    for (int i = 0; i < 20; i++) q.push_back(($urandom_range(0, 2) == 0) ? 8'h3B : 8'h62);
    for (int i = 0; i < 10; i++) send_byte(q[i], 1'b0);
    wait_drain();
    for (int i = 10; i < 20; i++) send_byte(q[i], i == 19);
    wait_drain();
  endtask

  // Random configs over a small alphabet so separators overlap and collide;
  // the last phase runs with no idling on either side.
  task automatic test_random_strings();
    byte_t       alpha [3];
    logic [31:0] words [4];
    logic [2:0]  count;
    logic [7:0]  pack;
    int          first_byte;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      alpha[0] = 8'($urandom_range(0, 255));
      alpha[1] = 8'($urandom_range(0, 255));
      alpha[2] = (phase % 2) ? 8'hFF : 8'h00;
      foreach (words[s])
        for (int k = 0; k < 4; k++) words[s][8*k +: 8] = alpha[$urandom_range(0, 2)];
      count = (phase == 0) ? 3'd4 : 3'($urandom_range(0, 7));
      pack  = (phase == 1) ? 8'hFF : (phase == 2) ? 8'h00 : 8'($urandom_range(0, 255));
      load_config(count, pack, words[0], words[1], words[2], words[3]);
      tx_steady  = (phase == RANDOM_PHASES - 1);
      rx_steady  = (phase == RANDOM_PHASES - 1);
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < PHASE_BYTES) send_random_string(alpha, 14);
      wait_drain();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_slot_separators();
    test_count_clamp();
    test_spare_index();
    test_back_pressure();
    test_sender_pause();
    test_random_strings();
    wait_drain();
    $display("Ran %0d bytes in %0d strings under %0d separator setups,", bytes_sent,
             strings_sent, config_sets);
    $display("compared %0d tokens, with output hold-off and a sender pause mid-string.",
             tokens_checked);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/mdt_pkg.sv
rtl/mdt_cell.sv
rtl/mdt_match.sv
rtl/multi_delimiter_tokenizer.sv
rtl/mdt_checker.sv
dv/testbench.sv
